// ===== rtl/igvt_pkg.sv =====
`timescale 1ns / 1ps
package igvt_pkg;
	localparam int unsigned CFG_W = 24;
	localparam int unsigned IDX_W = 8;
	localparam logic [IDX_W-1:0] REG_MEAN = 8'd0;
	localparam logic [IDX_W-1:0] REG_SHAPE = 8'd1;
	localparam logic [CFG_W-1:0] MEAN_RST = 24'd65536;
	localparam logic [CFG_W-1:0] SHAPE_RST = 24'd65536;
	localparam int unsigned SAMP_W = 16;
	localparam int unsigned OUT_W = 32;
	localparam int unsigned W_W = 55;
	localparam int unsigned F_SHIFT = 26;
	localparam int unsigned RS_W = 31;
	localparam int unsigned K_W = 5;

	typedef struct packed {
		logic [CFG_W-1:0] x;
		logic accept;
		logic ovf;
		logic last;
	} tail_side_t;
endpackage

// ===== rtl/igvt_sqrt.sv =====
`timescale 1ns / 1ps
module igvt_sqrt #(
	parameter int unsigned RW = 31,
	parameter int unsigned SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] in_n,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [RW-1:0]   out_root,
	output logic [SW-1:0]   out_side
);
	localparam int unsigned NW = 2 * RW;
	localparam int unsigned RMW = RW + 2;

	logic            v_s [0:RW];
	logic [NW-1:0]   n_s [0:RW];
	logic [RMW-1:0]  rem_s [0:RW];
	logic [RW-1:0]   root_s [0:RW];
	logic [SW-1:0]   side_s [0:RW];

	assign v_s[0] = in_valid;
	assign n_s[0] = in_n;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < RW; j++) begin : g_step
		logic [RMW+1:0] cur;
		logic [RMW+1:0] trial;
		logic           take;
		assign cur = {rem_s[j], n_s[j][NW-1 -: 2]};
		assign trial = (RMW+2)'({root_s[j], 2'b01});
		assign take = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j+1] <= n_s[j] << 2;
				rem_s[j+1] <= take ? RMW'(cur - trial) : RMW'(cur);
				root_s[j+1] <= {root_s[j][RW-2:0], take};
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign out_root = root_s[RW];
	assign out_side = side_s[RW];
endmodule

// ===== rtl/igvt_div.sv =====
`timescale 1ns / 1ps
module igvt_div #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 24,
	parameter int unsigned Q_W = 32,
	parameter int unsigned SW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [SW-1:0]    in_side,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quot,
	output logic [SW-1:0]    out_side
);
	localparam int unsigned RW = DEN_W + Q_W;

	logic             v_s [0:Q_W];
	logic [RW-1:0]    rem_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [Q_W-1:0]   q_s [0:Q_W];
	logic [SW-1:0]    side_s [0:Q_W];

	assign v_s[0] = in_valid;
	assign rem_s[0] = RW'(in_num);
	assign den_s[0] = in_den;
	assign q_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [RW-1:0] trial;
		logic          take;
		assign trial = RW'(den_s[i]) << (Q_W - 1 - i);
		assign take = rem_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - trial : rem_s[i];
				den_s[i+1] <= den_s[i];
				q_s[i+1] <= {q_s[i][Q_W-2:0], take};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign out_quot = q_s[Q_W];
	assign out_side = side_s[Q_W];
endmodule

// ===== rtl/inverse_gaussian_variate_transform_core.sv =====
`timescale 1ns / 1ps
// channel  | direction | payload
// s_axis   | in        | tdata {uniform_sample, normal_sample}, tlast last_in
// m_axis   | out       | tdata variate, tuser saturated, tlast last_out
// cfg      | in        | cfg_index, cfg_data (24 bit)
// one item per cycle while the output is not stalled; 7 front stages, 31 root stages,
// 1 stage, 24 quotient stages, 2 stages, 32 quotient stages, output register
// reset clears valid bits and loads mean and shape with 1.0
// the whole pipeline holds while the output register is full and not taken
module inverse_gaussian_variate_transform_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // normal_sample[15:0], uniform_sample[31:16]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // variate[31:0]
	output logic        m_axis_tuser,  // saturated
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam int unsigned CW = igvt_pkg::CFG_W;
	localparam int unsigned SW = igvt_pkg::SAMP_W;
	localparam int unsigned RS = igvt_pkg::RS_W;

	logic [CW-1:0] mean_q, shape_q;
	logic en;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= igvt_pkg::MEAN_RST;
			shape_q <= igvt_pkg::SHAPE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				igvt_pkg::REG_MEAN:  mean_q <= cfg_data;
				igvt_pkg::REG_SHAPE: shape_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic [6:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], s_axis_tvalid};
		end
	end

	logic [SW-1:0] mag_s1, u_s1, u_s2, u_s3, u_s4, u_s5, u_s6, u_s7;
	logic [6:0] last_sr_q;
	logic [2*SW-2:0] zsq_s2;
	logic [igvt_pkg::W_W-1:0] w_s3, w_s4, w_s5, f_s3, f_s4, f_s5, sum_s4;
	logic [igvt_pkg::K_W-1:0] k0_s5;
	logic [RS-1:0] ws_s6, fs_s6, ws_s7;
	logic [2*RS-1:0] p_s7;

	logic [SW-1:0] zin;
	assign zin = s_axis_tdata[SW-1:0];

	logic [igvt_pkg::K_W-1:0] k0_c, ka_c;
	logic [igvt_pkg::W_W-1:0] wa_c, fa_c, wb_c, fb_c, suma_c;
	always_comb begin
		k0_c = '0;
		for (int i = RS; i < igvt_pkg::W_W; i++) begin
			if (sum_s4[i]) k0_c = igvt_pkg::K_W'(i - RS + 1);
		end
		ka_c = (k0_s5 == '0) ? '0 : k0_s5 - 1'b1;
		wa_c = w_s5 >> ka_c;
		fa_c = f_s5 >> ka_c;
		wb_c = w_s5 >> k0_s5;
		fb_c = f_s5 >> k0_s5;
		suma_c = wa_c + fa_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= zin[SW-1] ? SW'(~zin + 1'b1) : zin;
			u_s1 <= s_axis_tdata[2*SW-1:SW];
			last_sr_q <= {last_sr_q[5:0], s_axis_tlast};
			zsq_s2 <= (2*SW-1)'(mag_s1 * mag_s1);
			u_s2 <= u_s1;
			w_s3 <= igvt_pkg::W_W'(mean_q * zsq_s2);
			f_s3 <= igvt_pkg::W_W'(shape_q) << igvt_pkg::F_SHIFT;
			u_s3 <= u_s2;
			sum_s4 <= w_s3 + f_s3;
			w_s4 <= w_s3;
			f_s4 <= f_s3;
			u_s4 <= u_s3;
			k0_s5 <= k0_c;
			w_s5 <= w_s4;
			f_s5 <= f_s4;
			u_s5 <= u_s4;
			if (suma_c[igvt_pkg::W_W-1:RS] == '0) begin
				ws_s6 <= RS'(wa_c);
				fs_s6 <= RS'(fa_c);
			end else begin
				ws_s6 <= RS'(wb_c);
				fs_s6 <= RS'(fb_c);
			end
			u_s6 <= u_s5;
			p_s7 <= (2*RS)'(ws_s6 * (RS+1)'(ws_s6 + fs_s6));
			ws_s7 <= ws_s6;
			u_s7 <= u_s6;
		end
	end

	localparam int unsigned SQ_SW = RS + SW + 1;
	logic sq_v;
	logic [RS-1:0] sq_root;
	logic [SQ_SW-1:0] sq_side;

	igvt_sqrt #(.RW(RS), .SW(SQ_SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_q[6]), .in_n(p_s7),
		.in_side({ws_s7, u_s7, last_sr_q[6]}),
		.out_valid(sq_v), .out_root(sq_root), .out_side(sq_side)
	);

	localparam int unsigned N1_W = CW + RS;
	localparam int unsigned D1_W = RS + 1;
	logic [RS-1:0] sq_ws;
	assign sq_ws = sq_side[SQ_SW-1 -: RS];

	logic v_s8;
	logic [N1_W-1:0] num_s8;
	logic [D1_W-1:0] den_s8;
	logic [SW:0] side_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= sq_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (sq_ws == '0) begin
				num_s8 <= N1_W'(mean_q);
				den_s8 <= D1_W'(1);
			end else begin
				num_s8 <= N1_W'(mean_q * (sq_root - sq_ws));
				den_s8 <= D1_W'(sq_root) + D1_W'(sq_ws);
			end
			side_s8 <= sq_side[SW:0];
		end
	end

	logic d1_v;
	logic [CW-1:0] d1_x;
	logic [SW:0] d1_side;
	igvt_div #(.NUM_W(N1_W), .DEN_W(D1_W), .Q_W(CW), .SW(SW+1)) u_div_root (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s8), .in_num(num_s8), .in_den(den_s8), .in_side(side_s8),
		.out_valid(d1_v), .out_quot(d1_x), .out_side(d1_side)
	);

	localparam int unsigned OUT_W_EXT = CW + igvt_pkg::OUT_W;
	logic v_s9, v_s10;
	logic [CW-1:0] x_s9;
	logic acc_s9, last_s9;
	logic [2*CW-1:0] mm_s10;
	igvt_pkg::tail_side_t side_s10;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s9 <= d1_v;
			v_s10 <= v_s9;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s9 <= d1_x;
			acc_s9 <= (SW+CW+1)'(d1_side[SW:1] * ((CW+1)'(mean_q) + (CW+1)'(d1_x)))
				< ((SW+CW+1)'(mean_q) << SW);
			last_s9 <= d1_side[0];
			mm_s10 <= (2*CW)'(mean_q * mean_q);
			side_s10.x <= x_s9;
			side_s10.accept <= acc_s9;
			side_s10.ovf <= (OUT_W_EXT'(mean_q * mean_q)) >= (OUT_W_EXT'(x_s9) << igvt_pkg::OUT_W);
			side_s10.last <= last_s9;
		end
	end

	logic d2_v;
	logic [igvt_pkg::OUT_W-1:0] d2_q;
	igvt_pkg::tail_side_t d2_side;
	igvt_div #(.NUM_W(2*CW), .DEN_W(CW), .Q_W(igvt_pkg::OUT_W),
		.SW($bits(igvt_pkg::tail_side_t))) u_div_recip (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s10), .in_num(mm_s10), .in_den(side_s10.x), .in_side(side_s10),
		.out_valid(d2_v), .out_quot(d2_q), .out_side(d2_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= d2_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tlast <= d2_side.last;
			if (mean_q == '0 || shape_q == '0) begin
				m_axis_tdata <= '0;
				m_axis_tuser <= 1'b0;
			end else if (d2_side.accept) begin
				m_axis_tdata <= igvt_pkg::OUT_W'(d2_side.x);
				m_axis_tuser <= 1'b0;
			end else if (d2_side.ovf) begin
				m_axis_tdata <= '1;
				m_axis_tuser <= 1'b1;
			end else begin
				m_axis_tdata <= d2_q;
				m_axis_tuser <= 1'b0;
			end
		end
	end

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready)) else $error("ready mismatch");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '1) else $error("sat value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("item dropped");
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q)) else $error("front moved in stall");
endmodule

// ===== tb/sv/inverse_gaussian_variate_transform_core_test.sv =====
`timescale 1ns / 1ps
module inverse_gaussian_variate_transform_core_test;
	typedef struct {
		logic [31:0] variate;
		logic        saturated;
		logic        last;
	} variate_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // normal_sample[15:0], uniform_sample[31:16]
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // variate[31:0]
	logic        m_axis_tuser;  // saturated
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [23:0] cfg_data;

	localparam int unsigned LATENCY = 98;
	localparam longint CYCLE_LIMIT = 400000;

	logic [23:0] mean_q;
	logic [23:0] shape_q;
	variate_t    expected_variates[$];
	int          mismatches;
	int          items_sent;
	int          results_seen;
	int          saturations_seen;
	longint      cycle_count;
	bit          stall_enable;
	bit          hold_sink;

	inverse_gaussian_variate_transform_core dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic variate_t predict_variate(logic [15:0] z, logic [15:0] u, logic last);
		variate_t r;
		logic [63:0] m, l, mag, w, f, ws, fs, s, x, q;
		int k;
		m = mean_q;
		l = shape_q;
		r.variate = 0;
		r.saturated = 0;
		r.last = last;
		if (m != 0 && l != 0) begin
			mag = z[15] ? (64'h10000 - z) : z;
			w = m * mag * mag;
			f = l << igvt_pkg::F_SHIFT;
			ws = w;
			fs = f;
			k = 0;
			while (k < 63 && (ws + fs) >= 64'h8000_0000) begin
				k++;
				ws = w >> k;
				fs = f >> k;
			end
			if (ws == 0) begin
				x = m;
			end else begin
				s = int_sqrt(ws * (ws + fs));
				x = (m * (s - ws)) / (s + ws);
			end
			if (u * (m + x) < (m << 16)) begin
				r.variate = x[31:0];
			end else if (x == 0) begin
				r.variate = '1;
				r.saturated = 1;
			end else begin
				q = (m * m) / x;
				if (q > 64'hFFFF_FFFF) begin
					r.variate = '1;
					r.saturated = 1;
				end else begin
					r.variate = q[31:0];
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		mismatches++;
	endtask

	// sink: random stalls, plus a long hold when requested
	always @(posedge clk) begin
		variate_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_variates.size() == 0) begin
				report_mismatch("unexpected item", m_axis_tdata, 0);
			end else begin
				e = expected_variates.pop_front();
				if (m_axis_tdata !== e.variate)
					report_mismatch("variate", m_axis_tdata, e.variate);
				if (m_axis_tuser !== e.saturated)
					report_mismatch("saturated", m_axis_tuser, e.saturated);
				if (m_axis_tlast !== e.last)
					report_mismatch("last", m_axis_tlast, e.last);
				if (e.saturated)
					saturations_seen++;
			end
		end
	end

	initial begin
		int wait_cycles;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				repeat (2500) @(posedge clk);
				hold_sink = 0;
			end
			wait_cycles = stall_enable ? $urandom_range(0, 18) : 0;
			if (stall_enable && $urandom_range(0, 2) == 0)
				wait_cycles = 0;
			if (wait_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_sample(logic [15:0] z, logic [15:0] u, logic last);
		int gap;
		gap = stall_enable ? $urandom_range(0, 18) : 0;
		if (stall_enable && $urandom_range(0, 2) == 0)
			gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {u, z};
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_variates.push_back(predict_variate(z, u, last));
		items_sent++;
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (expected_variates.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_register(logic [7:0] index, logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == igvt_pkg::REG_MEAN)
			mean_q = value;
		else if (index == igvt_pkg::REG_SHAPE)
			shape_q = value;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_normal();
		case ($urandom_range(0, 3))
			0: return 16'($signed($urandom_range(0, 8191)) - 4096);
			1: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	task automatic test_directed_extremes();
		logic [15:0] zs[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
			16'h1000, 16'hF000, 16'h5555};
		logic [15:0] us[3] = '{16'h0000, 16'hFFFF, 16'h8000};
		foreach (zs[i])
			foreach (us[j])
				if (i * 3 + j < 24)
					send_sample(zs[i], us[j], 1'((i + j) % 2));
		drain_pipeline();
	endtask

	task automatic test_zero_settings();
		write_register(igvt_pkg::REG_MEAN, 24'd0);
		send_sample(16'h1000, 16'h0000, 1'b0);
		send_sample(16'h8000, 16'hFFFF, 1'b1);
		drain_pipeline();
		write_register(igvt_pkg::REG_MEAN, 24'd65536);
		write_register(igvt_pkg::REG_SHAPE, 24'd0);
		send_sample(16'h1000, 16'hFFFF, 1'b1);
		drain_pipeline();
	endtask

	task automatic test_random_phase(logic [23:0] mean, logic [23:0] shape, int count);
		write_register(igvt_pkg::REG_MEAN, mean);
		write_register(igvt_pkg::REG_SHAPE, shape);
		for (int i = 0; i < count; i++)
			send_sample(random_normal(), 16'($urandom), $urandom_range(0, 7) == 0);
		drain_pipeline();
	endtask

	task automatic test_backpressure();
		hold_sink = 1;
		for (int i = 0; i < 200; i++)
			send_sample(random_normal(), 16'($urandom), i % 16 == 15);
		drain_pipeline();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mean_q = igvt_pkg::MEAN_RST;
		shape_q = igvt_pkg::SHAPE_RST;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		saturations_seen = 0;
		cycle_count = 0;
		stall_enable = 0;
		hold_sink = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		stall_enable = 1;
		test_zero_settings();
		test_random_phase(24'd65536, 24'd65536, 250);
		test_random_phase(24'hFFFFFF, 24'hFFFFFF, 150);
		test_random_phase(24'hFFFFFF, 24'd1, 150);
		test_random_phase(24'd1, 24'hFFFFFF, 150);
		test_random_phase(24'd1, 24'd1, 100);
		stall_enable = 0;
		test_random_phase(24'($urandom), 24'($urandom), 200);
		stall_enable = 1;
		test_random_phase(24'($urandom_range(1, 24'h0FFFFF)), 24'($urandom), 200);
		test_random_phase(24'h800000, 24'h000100, 150);
		test_backpressure();
		$display("%0d items sent, %0d results checked, %0d saturated", items_sent,
			results_seen, saturations_seen);
		$display("covered extremes, zero mean and shape, and stalled output");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
